// File: sv/b8d_pkg.sv
package b8d_pkg;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAR  = 2'd1,
        ST_BAD_LEN   = 2'd2,
        ST_MISMATCH  = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        t_status    status;
        logic       end_of_stream;
    } t_result;

endpackage

// File: sv/b8d_front.sv
module b8d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_accept,
    input  logic [7:0]       i_digit_char,
    input  logic             i_last,
    output logic             o_push,
    output b8d_pkg::t_result o_result
);
    import b8d_pkg::*;

    localparam logic [7:0] START_CHAR_RESET = 8'd48;
    localparam logic [2:0] POS_BYTE0 = 3'd2;
    localparam logic [2:0] POS_BYTE1 = 3'd5;
    localparam logic [2:0] POS_BYTE2 = 3'd7;

    logic [7:0] r_start_char;
    logic [2:0] r_phase;
    logic [9:0] r_buf;
    logic [1:0] r_ones;
    logic       r_bad_seen;

    logic [2:0] n_phase;
    logic [9:0] n_buf;
    logic [1:0] n_ones;
    logic       n_bad_seen;

    logic [7:0] diff;
    logic [2:0] digit;
    logic [1:0] digit_ones;
    logic       bad_char;
    logic [9:0] shifted;
    logic       have_byte;
    logic [7:0] byte_val;
    t_status    status;

    always_comb begin
        diff       = i_digit_char - r_start_char;
        digit      = diff[2:0];
        digit_ones = {1'b0, digit[0]} + {1'b0, digit[1]} + {1'b0, digit[2]};
        // upper bound compared in 9 bits so a high start code cannot wrap
        bad_char   = (i_digit_char < r_start_char) ||
                     ({1'b0, i_digit_char} > ({1'b0, r_start_char} + 9'd7));
        shifted    = {r_buf[6:0], digit};
        n_bad_seen = r_bad_seen | bad_char;
        n_ones     = i_last ? r_ones : (r_ones + digit_ones);
        n_phase    = r_phase + 3'd1;
        have_byte  = 1'b0;
        byte_val   = 8'd0;
        n_buf      = shifted;
        unique case (r_phase)
            POS_BYTE0: begin
                have_byte = 1'b1;
                byte_val  = shifted[8:1];
                n_buf     = {9'd0, shifted[0]};
            end
            POS_BYTE1: begin
                have_byte = 1'b1;
                byte_val  = shifted[9:2];
                n_buf     = {8'd0, shifted[1:0]};
            end
            POS_BYTE2: begin
                have_byte = 1'b1;
                byte_val  = shifted[7:0];
                n_buf     = 10'd0;
            end
            default: begin
            end
        endcase

        status = ST_OK;
        if (i_last) begin
            priority if (n_bad_seen) begin
                status = ST_BAD_CHAR;
            end else if (!have_byte) begin
                status = ST_BAD_LEN;
            end else if (r_phase == POS_BYTE0 && n_buf[0] != r_ones[0]) begin
                status = ST_MISMATCH;
            end else if (r_phase == POS_BYTE1 && n_buf[1:0] != r_ones) begin
                status = ST_MISMATCH;
            end else begin
                status = ST_OK;
            end
        end
    end

    assign o_push                 = i_accept && (have_byte || i_last);
    assign o_result.data_byte     = byte_val;
    assign o_result.byte_valid    = have_byte;
    assign o_result.status        = status;
    assign o_result.end_of_stream = i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= START_CHAR_RESET;
            r_phase      <= 3'd0;
            r_buf        <= 10'd0;
            r_ones       <= 2'd0;
            r_bad_seen   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_start_char <= i_cfg_data;
            end
            if (i_accept) begin
                if (i_last) begin
                    r_phase    <= 3'd0;
                    r_buf      <= 10'd0;
                    r_ones     <= 2'd0;
                    r_bad_seen <= 1'b0;
                end else begin
                    r_phase    <= n_phase;
                    r_buf      <= n_buf;
                    r_ones     <= n_ones;
                    r_bad_seen <= n_bad_seen;
                end
            end
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_phase == 3'd0 && r_buf == 10'd0 && !r_bad_seen)
        else $error("stream state not cleared after last beat");

    a_group_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == POS_BYTE2 |=> r_buf == 10'd0 && r_phase == 3'd0)
        else $error("bit buffer not empty at group end");

    a_push_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> o_result.byte_valid || o_result.end_of_stream)
        else $error("result pushed with neither byte nor end");

endmodule

// File: sv/b8d_queue.sv
module b8d_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b8d_pkg::t_result i_data,
    input  logic             i_pop,
    output b8d_pkg::t_result o_data,
    output logic             o_empty,
    output logic             o_full
);
    import b8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_result          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");

endmodule

// File: sv/b8d_back.sv
module b8d_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  b8d_pkg::t_result i_data,
    input  logic             i_empty,
    output logic             o_pop,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output b8d_pkg::t_result o_result
);
    import b8d_pkg::*;

    logic    r_valid;
    t_result r_result;

    // output register refills whenever it is empty or its beat is taken
    assign o_pop       = !i_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_data;
        end
    end

endmodule

// File: sv/base8_decoder_with_check_digit.sv
// Octal text decoder: one character beat in per cycle unless stalled, a result beat
// out when a byte completes (digits 3, 6 and 8 of each group of eight) or on the last
// character, which also carries the final status. The front stage decodes and updates
// the stream state in the accept cycle; results pass through a QUEUE_DEPTH-entry queue
// to an output register. o_in_stall rises only when the queue is full; with the output
// side free the block sustains one character per cycle. start_char is written via
// i_cfg_we only while the block is idle; the user must ensure this, the block does not.
module base8_decoder_with_check_digit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_digit_char,
    input  logic       i_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic [1:0] o_status,
    output logic       o_end_of_stream
);
    import b8d_pkg::*;

    logic    accept;
    logic    push;
    logic    pop;
    logic    q_empty;
    logic    q_full;
    t_result front_res;
    t_result q_res;
    t_result out_res;

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    b8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_digit_char (i_digit_char),
        .i_last       (i_last),
        .o_push       (push),
        .o_result     (front_res)
    );

    b8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    b8d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (q_res),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (out_res)
    );

    assign o_data_byte     = out_res.data_byte;
    assign o_byte_valid    = out_res.byte_valid;
    assign o_status        = out_res.status;
    assign o_end_of_stream = out_res.end_of_stream;

endmodule
